### hdl/rrqs_pkg.sv
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared constants, codes and control types of the round-robin time-slice
// scheduler.
// ----------------------------------------------------------------------------
package rrqs_pkg;

    // Default ring depth and stored time width.
    localparam int DEPTH_DEFAULT     = 16;
    localparam int TIME_BITS_DEFAULT = 16;

    // Fixed port widths.
    localparam int ID_W     = 8;
    localparam int IO_TIME_W = 16;
    localparam int OCC_W    = 5;
    localparam int STATUS_W = 2;

    // Quantum value after reset.
    localparam logic [IO_TIME_W-1:0] QUANTUM_RESET = 16'd2;

    // Operation codes of the func field.
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_SERVE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic add;      // append the incoming process at the tail
        logic reject;   // report an add on a full ring
        logic empty;    // report a serve on an empty ring
        logic read;     // start the read of the head entry
        logic serve;    // finish a serve with the head entry read out
    } rrqs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic res_pending;
    } rrqs_stat_t;

endpackage

### hdl/rrqs_ram.sv
// ----------------------------------------------------------------------------
// rrqs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rrqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/rrqs_ctrl.sv
// ----------------------------------------------------------------------------
// rrqs_ctrl
// Controller of the scheduler: takes input items and sequences the ring
// operations that the datapath carries out.
// ----------------------------------------------------------------------------
module rrqs_ctrl
    import rrqs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  rrqs_stat_t stat,
    output rrqs_cmd_t  cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // An item is taken only when idle and the result slot is free.
    assign s_ready = (state_reg == ST_IDLE) && !stat.res_pending;
    assign accept  = s_valid && s_ready;

    // Command decode and next state.
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_func == FUNC_ADD) begin
                        cmd.add    = !stat.full;
                        cmd.reject = stat.full;
                    end else if (stat.empty) begin
                        cmd.empty = 1'b1;
                    end else begin
                        cmd.read   = 1'b1;
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                cmd.serve  = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/rrqs_datapath.sv
// ----------------------------------------------------------------------------
// rrqs_datapath
// Datapath of the scheduler: ring storage, head and count registers, the
// quantum register, the slice subtraction and the result registers.
// ----------------------------------------------------------------------------
module rrqs_datapath
    import rrqs_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [IO_TIME_W-1:0] cfg_wr_data,
    input  logic [ID_W-1:0]      s_process_id,
    input  logic [IO_TIME_W-1:0] s_burst_time,
    input  rrqs_cmd_t            cmd,
    output rrqs_stat_t           stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ID_W-1:0]      m_served_id,
    output logic [IO_TIME_W-1:0] m_time_left,
    output logic                 m_finished,
    output logic [STATUS_W-1:0]  m_status,
    output logic [OCC_W-1:0]     m_occupancy
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int ENTRY_W = ID_W + TIME_BITS;
    localparam int CMP_W   = (TIME_BITS > IO_TIME_W) ? TIME_BITS : IO_TIME_W;

    logic [PTR_W-1:0]     head_reg;
    logic [PTR_W-1:0]     head_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [IO_TIME_W-1:0] quantum_reg;

    // Pending result slot and output register.
    logic                 res_valid_reg;
    logic [ID_W-1:0]      res_id_reg;
    logic [TIME_BITS-1:0] res_time_reg;
    logic                 res_fin_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [CNT_W-1:0]     res_count_reg;
    logic                 res_load;
    logic [ID_W-1:0]      res_id_next;
    logic [TIME_BITS-1:0] res_time_next;
    logic                 res_fin_next;
    logic [STATUS_W-1:0]  res_status_next;

    logic                 out_valid_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [TIME_BITS-1:0] out_time_reg;
    logic                 out_fin_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [CNT_W-1:0]     out_count_reg;
    logic                 out_load;

    logic [SUM_W-1:0]               tail_sum;
    logic [SUM_W-1:0]               tail_wrap;
    logic [PTR_W-1:0]               tail_ptr;
    logic [IO_TIME_W+TIME_BITS-1:0] burst_wide;
    logic [TIME_BITS-1:0]           burst;
    logic [ENTRY_W-1:0]             rd_data;
    logic [ID_W-1:0]                head_id;
    logic [CMP_W-1:0]               head_time;
    logic [CMP_W-1:0]               quantum_ext;
    logic [CMP_W-1:0]               diff;
    logic                           requeue;
    logic                           wr_en;
    logic [ENTRY_W-1:0]             wr_data;
    logic [IO_TIME_W+TIME_BITS-1:0] time_out_wide;
    logic [OCC_W+CNT_W-1:0]         occ_wide;

    assign stat.full        = (count_reg == CNT_W'(DEPTH));
    assign stat.empty       = (count_reg == '0);
    assign stat.res_pending = res_valid_reg;

    // The tail sits count entries past the head, modulo the depth. After a
    // pop the head moves on and the count drops, so the tail stays put.
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? (tail_sum - SUM_W'(DEPTH)) : tail_sum;
    assign tail_ptr  = tail_wrap[PTR_W-1:0];

    // Burst time kept in the stored time width.
    assign burst_wide = {{TIME_BITS{1'b0}}, s_burst_time};
    assign burst      = burst_wide[TIME_BITS-1:0];

    // Slice subtraction on the head entry.
    assign head_id     = rd_data[ENTRY_W-1:TIME_BITS];
    assign head_time   = CMP_W'(rd_data[TIME_BITS-1:0]);
    assign quantum_ext = CMP_W'(quantum_reg);
    assign requeue     = (head_time > quantum_ext);
    assign diff        = head_time - quantum_ext;

    // Ring write: a new process or a requeued one, always at the tail.
    assign wr_en   = cmd.add || (cmd.serve && requeue);
    assign wr_data = cmd.add ? {s_process_id, burst} : {head_id, diff[TIME_BITS-1:0]};

    rrqs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_ptr),
        .wr_data (wr_data),
        .rd_en   (cmd.read),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    // Head and count updates.
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.add) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.serve) begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
            if (!requeue) begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    // Result of the item that completes in this cycle.
    always_comb begin
        res_load        = cmd.add || cmd.reject || cmd.empty || cmd.serve;
        res_id_next     = s_process_id;
        res_time_next   = '0;
        res_fin_next    = 1'b0;
        res_status_next = STATUS_OK;
        if (cmd.add) begin
            res_time_next = burst;
        end else if (cmd.reject) begin
            res_status_next = STATUS_FULL;
        end else if (cmd.empty) begin
            res_id_next     = '0;
            res_status_next = STATUS_EMPTY;
        end else if (cmd.serve) begin
            res_id_next = head_id;
            if (requeue) begin
                res_time_next = diff[TIME_BITS-1:0];
            end else begin
                res_fin_next = 1'b1;
            end
        end
    end

    assign out_load = res_valid_reg && (!out_valid_reg || m_ready);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            count_reg     <= '0;
            quantum_reg   <= QUANTUM_RESET;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cfg_wr_en) begin
                quantum_reg <= cfg_wr_data;
            end
            if (res_load) begin
                res_valid_reg <= 1'b1;
            end else if (out_load) begin
                res_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_id_reg     <= res_id_next;
            res_time_reg   <= res_time_next;
            res_fin_reg    <= res_fin_next;
            res_status_reg <= res_status_next;
            res_count_reg  <= count_next;
        end
        if (out_load) begin
            out_id_reg     <= res_id_reg;
            out_time_reg   <= res_time_reg;
            out_fin_reg    <= res_fin_reg;
            out_status_reg <= res_status_reg;
            out_count_reg  <= res_count_reg;
        end
    end

    // Output ports in their fixed widths.
    assign time_out_wide = {{IO_TIME_W{1'b0}}, out_time_reg};
    assign occ_wide      = {{OCC_W{1'b0}}, out_count_reg};
    assign m_valid       = out_valid_reg;
    assign m_served_id   = out_id_reg;
    assign m_time_left   = time_out_wide[IO_TIME_W-1:0];
    assign m_finished    = out_fin_reg;
    assign m_status      = out_status_reg;
    assign m_occupancy   = occ_wide[OCC_W-1:0];

endmodule

### hdl/round_robin_quantum_scheduler_top.sv
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_top
// Round-robin time-slice scheduler over a ring of up to DEPTH processes.
// ----------------------------------------------------------------------------
// An add, a rejected add and a serve on an empty ring load their result into
// a one-entry result slot at the accepting edge; it moves into the output
// register at the next edge when that register is free or m_ready is high,
// and s_ready stays low while the slot is occupied. A serve of a non-empty
// ring first reads the head entry out of the ring RAM through its registered
// read port; the slice is then subtracted, the entry is written back at the
// tail and the result is loaded into the slot. m_valid is high while the
// output register holds a result. While the output register waits for
// m_ready, one more item can be taken and held in the result slot; after
// that the input stalls until the output transfer.
// The quantum register is written through cfg_wr_en and cfg_wr_data and
// resets to 2.
module round_robin_quantum_scheduler_top
    import rrqs_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [IO_TIME_W-1:0] cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_func,
    input  logic [ID_W-1:0]      s_process_id,
    input  logic [IO_TIME_W-1:0] s_burst_time,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ID_W-1:0]      m_served_id,
    output logic [IO_TIME_W-1:0] m_time_left,
    output logic                 m_finished,
    output logic [STATUS_W-1:0]  m_status,
    output logic [OCC_W-1:0]     m_occupancy
);

    rrqs_cmd_t  cmd;
    rrqs_stat_t stat;

    rrqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .stat    (stat),
        .cmd     (cmd)
    );

    rrqs_datapath #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_process_id (s_process_id),
        .s_burst_time (s_burst_time),
        .cmd          (cmd),
        .stat         (stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_served_id  (m_served_id),
        .m_time_left  (m_time_left),
        .m_finished   (m_finished),
        .m_status     (m_status),
        .m_occupancy  (m_occupancy)
    );

endmodule

### hdl/rrqs_checker.sv
// ----------------------------------------------------------------------------
// rrqs_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrqs_checker
    import rrqs_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [ID_W-1:0]      m_served_id,
    input logic [IO_TIME_W-1:0] m_time_left,
    input logic                 m_finished,
    input logic [STATUS_W-1:0]  m_status,
    input logic [OCC_W-1:0]     m_occupancy
);

    // A result that is not taken stays with the same contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_served_id) && $stable(m_time_left)
            && $stable(m_finished) && $stable(m_status) && $stable(m_occupancy))
        else $error("result changed while stalled");

    // A serve on an empty ring leaves it empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_EMPTY) |-> (m_occupancy == '0) && !m_finished)
        else $error("empty report with nonzero occupancy");

    // A finished process carries no remaining time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_finished |-> (m_status == STATUS_OK) && (m_time_left == '0))
        else $error("finished process with time left");

    // A rejected add reports no time and no completion.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_FULL) |-> !m_finished && (m_time_left == '0))
        else $error("rejected add with time or completion");

endmodule

bind round_robin_quantum_scheduler_top rrqs_checker u_rrqs_checker (.*);

### verif/round_robin_quantum_scheduler_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_top_test
// Self-checking testbench of the round-robin time-slice scheduler. A short
// directed table covers serve on an empty ring, field extremes, a full ring,
// a zero burst and a burst equal to the quantum. Random add/serve traffic
// then runs under several quantum settings, with bursty input, a stalling
// output and one long output hold-off. Each result is compared field by
// field with a typed table result or an in-order prediction of the ring.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler_top_test;
    import rrqs_pkg::*;

    localparam int RING_DEPTH     = DEPTH_DEFAULT;
    localparam int ITEMS_PER_RUN  = 313;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int CYCLE_LIMIT    = 400000;

    // One result of the scheduler, as seen on the m_ side.
    typedef struct packed {
        logic [ID_W-1:0]      served_id;
        logic [IO_TIME_W-1:0] time_left;
        logic                 finished;
        logic [STATUS_W-1:0]  status;
        logic [OCC_W-1:0]     occupancy;
    } sched_result_t;

    // One row of the directed table; a typed result replaces the predicted one.
    typedef struct {
        logic                 func;
        logic [ID_W-1:0]      pid;
        logic [IO_TIME_W-1:0] burst;
        int                   reps;
        bit                   typed;
        sched_result_t        res;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [IO_TIME_W-1:0] cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_func = FUNC_ADD;
    logic [ID_W-1:0]      s_process_id = '0;
    logic [IO_TIME_W-1:0] s_burst_time = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [ID_W-1:0]      m_served_id;
    logic [IO_TIME_W-1:0] m_time_left;
    logic                 m_finished;
    logic [STATUS_W-1:0]  m_status;
    logic [OCC_W-1:0]     m_occupancy;

    // Side band that travels with the item being offered.
    bit            offer_typed = 1'b0;
    sched_result_t offer_result = '0;

    // Predicted ring contents and configuration.
    logic [ID_W-1:0]      ring_ids   [RING_DEPTH];
    logic [IO_TIME_W-1:0] ring_times [RING_DEPTH];
    logic [3:0]           ring_head = '0;
    logic [OCC_W-1:0]     ring_count = '0;
    logic [IO_TIME_W-1:0] cur_quantum = QUANTUM_RESET;

    sched_result_t pending_results [$];
    int            mismatch_count = 0;
    int            results_seen = 0;
    int            tb_cycles = 0;
    bit            long_hold_done = 1'b0;

    stim_row_t directed_rows [10] = '{
        '{FUNC_SERVE, 8'h00, 16'h0000, 1,  1'b1, '{8'h00, 16'h0000, 1'b0, STATUS_EMPTY, 5'd0}},
        '{FUNC_ADD,   8'hFF, 16'hFFFF, 1,  1'b1, '{8'hFF, 16'hFFFF, 1'b0, STATUS_OK,    5'd1}},
        '{FUNC_ADD,   8'h00, 16'h0000, 1,  1'b1, '{8'h00, 16'h0000, 1'b0, STATUS_OK,    5'd2}},
        '{FUNC_ADD,   8'h55, 16'h0002, 1,  1'b1, '{8'h55, 16'h0002, 1'b0, STATUS_OK,    5'd3}},
        '{FUNC_ADD,   8'h3C, 16'h8001, 13, 1'b0, '{8'h00, 16'h0000, 1'b0, STATUS_OK,    5'd0}},
        '{FUNC_ADD,   8'hC3, 16'h7FFE, 1,  1'b1, '{8'hC3, 16'h0000, 1'b0, STATUS_FULL,  5'd16}},
        '{FUNC_SERVE, 8'h00, 16'h0000, 1,  1'b0, '{8'h00, 16'h0000, 1'b0, STATUS_OK,    5'd0}},
        '{FUNC_SERVE, 8'h00, 16'h0000, 1,  1'b0, '{8'h00, 16'h0000, 1'b0, STATUS_OK,    5'd0}},
        '{FUNC_SERVE, 8'h00, 16'h0000, 1,  1'b0, '{8'h00, 16'h0000, 1'b0, STATUS_OK,    5'd0}},
        '{FUNC_ADD,   8'hAA, 16'h0001, 1,  1'b0, '{8'h00, 16'h0000, 1'b0, STATUS_OK,    5'd0}}
    };

    round_robin_quantum_scheduler_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_process_id (s_process_id),
        .s_burst_time (s_burst_time),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_served_id  (m_served_id),
        .m_time_left  (m_time_left),
        .m_finished   (m_finished),
        .m_status     (m_status),
        .m_occupancy  (m_occupancy)
    );

    // Clock generation.
    initial begin
        forever begin
            #10 aclk = ~aclk;
        end
    end

    // Run watchdog.
    always @(posedge aclk) begin
        tb_cycles <= tb_cycles + 1;
        if (tb_cycles > CYCLE_LIMIT) begin
            $display("round_robin_quantum_scheduler_top_test: FAIL");
            $finish;
        end
    end

    // Append a process at the predicted tail.
    function automatic void ring_push(input logic [ID_W-1:0] id,
                                      input logic [IO_TIME_W-1:0] t);
        logic [3:0] tail;
        tail = ring_head + ring_count[3:0];
        ring_ids[tail]   = id;
        ring_times[tail] = t;
        ring_count       = ring_count + 1'b1;
    endfunction

    // Advance the predicted ring by one item and return the result it causes.
    function automatic sched_result_t schedule_step(input logic func,
                                                    input logic [ID_W-1:0] pid,
                                                    input logic [IO_TIME_W-1:0] burst);
        sched_result_t        r;
        logic [ID_W-1:0]      id;
        logic [IO_TIME_W-1:0] t;
        r = '0;
        if (func == FUNC_ADD) begin
            r.served_id = pid;
            if (ring_count >= RING_DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                ring_push(pid, burst);
                r.time_left = burst;
                r.status    = STATUS_OK;
            end
        end else if (ring_count == 0) begin
            r.status = STATUS_EMPTY;
        end else begin
            id         = ring_ids[ring_head];
            t          = ring_times[ring_head];
            ring_head  = ring_head + 1'b1;
            ring_count = ring_count - 1'b1;
            r.served_id = id;
            r.status    = STATUS_OK;
            if (t > cur_quantum) begin
                ring_push(id, t - cur_quantum);
                r.time_left = t - cur_quantum;
            end else begin
                r.finished = 1'b1;
            end
        end
        r.occupancy = ring_count;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Predict on each input transfer; check each output transfer in order.
    always @(posedge aclk) begin
        sched_result_t want;
        sched_result_t predicted;
        if (m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: served_id %0h status %0h",
                       m_served_id, m_status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("served_id", want.served_id, m_served_id);
                check_field("time_left", want.time_left, m_time_left);
                check_field("finished",  want.finished,  m_finished);
                check_field("status",    want.status,    m_status);
                check_field("occupancy", want.occupancy, m_occupancy);
            end
        end
        if (aresetn && s_valid && s_ready) begin
            predicted = schedule_step(s_func, s_process_id, s_burst_time);
            pending_results.push_back(offer_typed ? offer_result : predicted);
        end
    end

    // Output side: changing stall patterns, plus one long hold-off.
    initial begin
        int mode;
        int mode_left;
        bit ready_next;
        mode = 0;
        mode_left = 0;
        forever begin
            @(negedge aclk);
            if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                long_hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                case (mode)
                    0: ready_next = 1'b1;
                    1: ready_next = $urandom_range(0, 1);
                    2: ready_next = ($urandom_range(0, 3) == 0);
                    default: ready_next = tb_cycles[2];
                endcase
                m_ready <= ready_next;
            end
        end
    end

    // Offer one item and hold it until the transfer happens.
    task automatic offer_item(input logic func, input logic [ID_W-1:0] pid,
                              input logic [IO_TIME_W-1:0] burst, input bit typed,
                              input sched_result_t res);
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_func       <= func;
        s_process_id <= pid;
        s_burst_time <= burst;
        offer_typed  <= typed;
        offer_result <= res;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic idle_input(input int cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Change the quantum once the scheduler has gone quiet.
    task automatic load_quantum(input logic [IO_TIME_W-1:0] value);
        idle_input(1);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_quantum = value;
    endtask

    // Random burst time: tiny, full range, near the quantum, or a few slices.
    function automatic logic [IO_TIME_W-1:0] pick_burst();
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 16);
            1: v = $urandom_range(0, 65535);
            2: v = int'(cur_quantum) + $urandom_range(0, 8) - 4;
            default: v = $urandom_range(0, 3 * int'(cur_quantum));
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[IO_TIME_W-1:0];
    endfunction

    // Random add/serve traffic in bursts with a per-burst mix of operations.
    task automatic run_random(input int count);
        int left;
        int burst_len;
        int add_pct;
        logic func;
        left = count;
        while (left > 0) begin
            burst_len = $urandom_range(1, 16);
            case ($urandom_range(0, 4))
                0: add_pct = 10;
                1: add_pct = 35;
                2: add_pct = 50;
                3: add_pct = 65;
                default: add_pct = 90;
            endcase
            for (int i = 0; i < burst_len && left > 0; i++) begin
                func = ($urandom_range(0, 99) < add_pct) ? FUNC_ADD : FUNC_SERVE;
                offer_item(func, $urandom_range(0, 255), pick_burst(), 1'b0, '0);
                left--;
            end
            if ($urandom_range(0, 3) != 0) begin
                idle_input($urandom_range(1, 6));
            end
        end
    endtask

    // Reset, directed table, then random traffic under each quantum setting.
    initial begin
        logic [IO_TIME_W-1:0] quanta [5];
        quanta[0] = 16'd0;
        quanta[1] = 16'd1;
        quanta[2] = 16'hFFFF;
        quanta[3] = $urandom_range(3, 40);
        quanta[4] = $urandom_range(2, 65534);

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                offer_item(directed_rows[r].func, directed_rows[r].pid,
                           directed_rows[r].burst, directed_rows[r].typed,
                           directed_rows[r].res);
            end
        end
        run_random(ITEMS_PER_RUN - 22);

        foreach (quanta[q]) begin
            load_quantum(quanta[q]);
            run_random(ITEMS_PER_RUN);
        end

        idle_input(1);
        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("round_robin_quantum_scheduler_top_test: PASS");
        end else begin
            $display("round_robin_quantum_scheduler_top_test: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
hdl/rrqs_pkg.sv
hdl/rrqs_ram.sv
hdl/rrqs_ctrl.sv
hdl/rrqs_datapath.sv
hdl/round_robin_quantum_scheduler_top.sv
hdl/rrqs_checker.sv
verif/round_robin_quantum_scheduler_top_test.sv
